@@ hdl/ucs_pkg.sv @@
package ucs_pkg;

  localparam int unsigned MaxSegmentBytes = 65535;
  localparam int unsigned UdpProtocol     = 17;
  localparam int unsigned CountW          = 17;
  localparam int unsigned SumW            = 17;
  localparam int unsigned LenW            = 16;
  localparam int unsigned TotalW          = 20;
  localparam int unsigned QueueDepth      = 2;
  localparam int unsigned QueuePtrW       = 1;
  localparam int unsigned QueueCntW       = 2;
  localparam int unsigned ChecksumFieldHi = 6;
  localparam int unsigned ChecksumFieldLo = 7;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } in_item_t;

  typedef struct packed {
    logic [15:0] checksum_value;
    logic        checksum_ok;
    logic        too_long;
  } out_item_t;

  typedef struct packed {
    logic            fill;
    logic [31:0]     src;
    logic [31:0]     dst;
    logic [SumW-1:0] sum;
    logic [LenW-1:0] len;
    logic            too_long;
  } job_t;

  typedef struct packed {
    logic full;
  } queue_ctl_t;

  function automatic logic [SumW-1:0] fold_add(input logic [SumW-1:0] acc,
                                              input logic [15:0]     v);
    logic [SumW:0] s;
    s = {1'b0, acc} + {2'b00, v};
    return {1'b0, s[15:0]} + {15'd0, s[SumW:16]};
  endfunction

endpackage

@@ hdl/ucs_front.sv @@
module ucs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ucs_pkg::in_item_t   in_data_i,
  input  ucs_pkg::queue_ctl_t q_ctl_i,
  output logic                push_o,
  output ucs_pkg::job_t       job_o
);

  logic                          in_seg_q, in_seg_d;
  logic                          odd_q, odd_d;
  logic                          fill_q, fill_d;
  logic [31:0]                   src_q, src_d;
  logic [31:0]                   dst_q, dst_d;
  logic [ucs_pkg::SumW-1:0]      sum_q, sum_d;
  logic [ucs_pkg::CountW-1:0]    cnt_q, cnt_d;
  logic [7:0]                    held_q, held_d;

  logic                          accept;
  logic                          first;
  logic                          odd_c;
  logic [ucs_pkg::SumW-1:0]      sum_c;
  logic [ucs_pkg::CountW-1:0]    cnt_c;
  logic [7:0]                    b;
  logic                          too_long;

  assign in_ready_o = !q_ctl_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign first      = !in_seg_q;

  always_comb begin
    odd_c    = first ? 1'b0 : odd_q;
    sum_c    = first ? '0 : sum_q;
    cnt_c    = first ? '0 : cnt_q;
    fill_d   = first ? in_data_i.func : fill_q;
    src_d    = first ? in_data_i.src_ip : src_q;
    dst_d    = first ? in_data_i.dst_ip : dst_q;
    b        = in_data_i.data_byte;
    if (fill_d && (cnt_c == ucs_pkg::CountW'(ucs_pkg::ChecksumFieldHi) ||
                   cnt_c == ucs_pkg::CountW'(ucs_pkg::ChecksumFieldLo))) begin
      b = 8'd0;
    end
    cnt_d = cnt_c;
    if (cnt_c <= ucs_pkg::CountW'(ucs_pkg::MaxSegmentBytes)) begin
      cnt_d = cnt_c + ucs_pkg::CountW'(1);
    end
    held_d = held_q;
    odd_d  = odd_c;
    sum_d  = sum_c;
    if (odd_c) begin
      sum_d = ucs_pkg::fold_add(sum_c, {held_q, b});
      odd_d = 1'b0;
    end else if (in_data_i.last_byte) begin
      sum_d = ucs_pkg::fold_add(sum_c, {b, 8'd0});
    end else begin
      held_d = b;
      odd_d  = 1'b1;
    end
    too_long = cnt_d > ucs_pkg::CountW'(ucs_pkg::MaxSegmentBytes);
    in_seg_d = !in_data_i.last_byte;
  end

  assign push_o         = accept && in_data_i.last_byte;
  assign job_o.fill     = fill_d;
  assign job_o.src      = src_d;
  assign job_o.dst      = dst_d;
  assign job_o.sum      = sum_d;
  assign job_o.too_long = too_long;
  assign job_o.len      = too_long ? ucs_pkg::LenW'(ucs_pkg::MaxSegmentBytes)
                                   : cnt_d[ucs_pkg::LenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seg_q <= 1'b0;
      odd_q    <= 1'b0;
      fill_q   <= 1'b0;
      sum_q    <= '0;
      cnt_q    <= '0;
      held_q   <= '0;
    end else if (accept) begin
      in_seg_q <= in_seg_d;
      odd_q    <= odd_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      held_q   <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && first) begin
      src_q <= src_d;
      dst_q <= dst_d;
    end
  end

endmodule

@@ hdl/ucs_queue.sv @@
module ucs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ucs_pkg::job_t       job_i,
  output ucs_pkg::queue_ctl_t ctl_o,
  input  logic                pop_i,
  output logic                avail_o,
  output ucs_pkg::job_t       job_o
);

  ucs_pkg::job_t                 mem_q [ucs_pkg::QueueDepth];
  logic [ucs_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ucs_pkg::QueueCntW-1:0] cnt_q;
  logic                          full;
  logic                          do_push, do_pop;

  assign full    = cnt_q == ucs_pkg::QueueCntW'(ucs_pkg::QueueDepth);
  assign avail_o = cnt_q != '0;
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && avail_o;
  assign job_o   = mem_q[rd_ptr_q];

  assign ctl_o.full = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == ucs_pkg::QueuePtrW'(ucs_pkg::QueueDepth - 1))
                    ? '0 : wr_ptr_q + ucs_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == ucs_pkg::QueuePtrW'(ucs_pkg::QueueDepth - 1))
                    ? '0 : rd_ptr_q + ucs_pkg::QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + ucs_pkg::QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - ucs_pkg::QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // The front never offers a segment end while the queue is full.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full))
    else $error("Segment end pushed into a full queue.");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ucs_pkg::QueueCntW'(ucs_pkg::QueueDepth))
    else $error("Queue occupancy exceeds its depth.");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + ucs_pkg::QueueCntW'(1)))
    else $error("Queue occupancy did not follow a push.");

endmodule

@@ hdl/ucs_back.sv @@
module ucs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  ucs_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ucs_pkg::out_item_t out_data_o
);

  logic                       s1_valid_q;
  logic [ucs_pkg::TotalW-1:0] s1_total_q, s1_total_d;
  logic                       s1_fill_q;
  logic                       s1_long_q;
  logic                       out_valid_q;
  ucs_pkg::out_item_t         out_q, out_d;
  logic                       out_en, s1_en;
  logic [16:0]                f1, f2;
  logic [15:0]                csum;

  assign out_en = !out_valid_q || out_ready_i;
  assign s1_en  = !s1_valid_q || out_en;
  assign pop_o  = avail_i && s1_en;

  assign s1_total_d = ucs_pkg::TotalW'(job_i.sum)
                    + ucs_pkg::TotalW'(job_i.src[31:16])
                    + ucs_pkg::TotalW'(job_i.src[15:0])
                    + ucs_pkg::TotalW'(job_i.dst[31:16])
                    + ucs_pkg::TotalW'(job_i.dst[15:0])
                    + ucs_pkg::TotalW'(ucs_pkg::UdpProtocol)
                    + ucs_pkg::TotalW'(job_i.len);

  always_comb begin
    f1 = {1'b0, s1_total_q[15:0]} + 17'(s1_total_q[ucs_pkg::TotalW-1:16]);
    f2 = {1'b0, f1[15:0]} + 17'(f1[16]);
    csum = ~f2[15:0];
    out_d.checksum_ok    = csum == 16'd0;
    out_d.checksum_value = (s1_fill_q && csum == 16'd0) ? 16'hFFFF : csum;
    out_d.too_long       = s1_long_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= avail_i;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_total_q <= s1_total_d;
      s1_fill_q  <= job_i.fill;
      s1_long_q  <= job_i.too_long;
    end
    if (out_en && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ok_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.checksum_ok == (out_q.checksum_value == 16'd0 ||
                     (out_q.checksum_value == 16'hFFFF && out_q.checksum_ok))))
    else $error("Checksum flag disagrees with the checksum value.");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_en) |=> out_valid_q)
    else $error("Summed segment was lost between stages.");

  a_pop_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!s1_valid_q || out_en))
    else $error("Queue popped while the sum stage was blocked.");

endmodule

@@ hdl/udp_checksum_engine_unit.sv @@
// UDP checksum engine with the IPv4 pseudo header.
// The input channel carries one segment byte per transfer in wire order,
// with the mode and both IPv4 addresses sampled on the first byte and
// last_byte marking the final byte. The output channel carries one result
// per segment: the checksum, a flag that the checksum verifies, and a flag
// for a segment longer than 65535 bytes.
// Throughput is one byte per cycle while in_ready_o is high, including
// back-to-back one-byte segments. Each 16-bit pair is folded in on its
// second byte; a lone last byte gets a zero low byte. Finished segments
// wait in a two-entry queue, then pass the sum stage, which adds the
// pseudo header terms, and the output register, which holds the folded
// and complemented result. When the receiver stalls, the output register
// and the sum stage hold, the queue fills, and in_ready_o falls only once
// two segments are waiting there.
// Reset clears the control state; the engine then waits for a first byte.
module udp_checksum_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ucs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ucs_pkg::out_item_t out_data_o
);

  ucs_pkg::queue_ctl_t q_ctl;
  ucs_pkg::job_t       push_job;
  ucs_pkg::job_t       head_job;
  logic                push;
  logic                pop;
  logic                avail;

  ucs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_ctl_i    (q_ctl),
    .push_o     (push),
    .job_o      (push_job)
  );

  ucs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ctl_o   (q_ctl),
    .pop_i   (pop),
    .avail_o (avail),
    .job_o   (head_job)
  );

  ucs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/udp_csum_checker.sv @@
`timescale 1ns / 100ps
module udp_csum_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  ucs_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  ucs_pkg::out_item_t out_data_i,
  output int unsigned        fails_o,
  output int unsigned        pending_o,
  output int unsigned        results_o
);

  logic [16:0] pair_sum;
  logic [16:0] byte_cnt;
  logic [7:0]  high_byte;
  logic        in_seg;
  logic        odd_half;
  logic        fill_mode;
  logic [31:0] src_q;
  logic [31:0] dst_q;

  ucs_pkg::out_item_t csum_q[$];
  int unsigned        n_fail;
  int unsigned        n_res;

  function automatic logic [16:0] add1c(input logic [16:0] acc,
                                        input logic [15:0] v);
    logic [17:0] s;
    s = 18'(acc) + 18'(v);
    return 17'(s[15:0]) + 17'(s[17:16]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [7:0]         b;
    logic [19:0]        tot;
    logic [15:0]        cs;
    logic [15:0]        seg_len;
    logic               ovr;
    ucs_pkg::out_item_t want;
    if (!rst_ni) begin
      pair_sum  = '0;
      byte_cnt  = '0;
      high_byte = '0;
      in_seg    = 1'b0;
      odd_half  = 1'b0;
      fill_mode = 1'b0;
      src_q     = '0;
      dst_q     = '0;
      csum_q.delete();
      n_fail    = 0;
      n_res     = 0;
      fails_o   <= 0;
      pending_o <= 0;
      results_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (csum_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("unexpected result: value %h ok %b long %b",
                     out_data_i.checksum_value, out_data_i.checksum_ok,
                     out_data_i.too_long);
          end
        end else begin
          want = csum_q.pop_front();
          n_res++;
          if (out_data_i.checksum_value !== want.checksum_value ||
              out_data_i.checksum_ok !== want.checksum_ok ||
              out_data_i.too_long !== want.too_long) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("mismatch on result %0d: expected value %h ok %b long %b,",
                       n_res, want.checksum_value, want.checksum_ok, want.too_long);
              $display("  got value %h ok %b long %b",
                       out_data_i.checksum_value, out_data_i.checksum_ok,
                       out_data_i.too_long);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        // Mode and addresses are taken from the first transfer of a segment only.
        if (!in_seg) begin
          in_seg    = 1'b1;
          fill_mode = in_data_i.func;
          src_q     = in_data_i.src_ip;
          dst_q     = in_data_i.dst_ip;
          pair_sum  = '0;
          byte_cnt  = '0;
          high_byte = '0;
          odd_half  = 1'b0;
        end
        b = in_data_i.data_byte;
        if (fill_mode && (byte_cnt == 17'd6 || byte_cnt == 17'd7)) begin
          b = 8'h00;
        end
        if (byte_cnt <= ucs_pkg::MaxSegmentBytes) begin
          byte_cnt = byte_cnt + 17'd1;
        end
        if (odd_half) begin
          pair_sum  = add1c(pair_sum, {high_byte, b});
          odd_half  = 1'b0;
          high_byte = 8'h00;
        end else if (in_data_i.last_byte) begin
          pair_sum = add1c(pair_sum, {b, 8'h00});
        end else begin
          high_byte = b;
          odd_half  = 1'b1;
        end
        if (in_data_i.last_byte) begin
          ovr     = byte_cnt > ucs_pkg::MaxSegmentBytes;
          seg_len = ovr ? 16'(ucs_pkg::MaxSegmentBytes) : byte_cnt[15:0];
          tot = 20'(pair_sum) + 20'(src_q[31:16]) + 20'(src_q[15:0]) +
                20'(dst_q[31:16]) + 20'(dst_q[15:0]) + 20'(ucs_pkg::UdpProtocol) +
                20'(seg_len);
          repeat (3) tot = 20'(tot[15:0]) + 20'(tot[19:16]);
          cs = ~tot[15:0];
          want.checksum_value = (fill_mode && cs == 16'h0000) ? 16'hFFFF : cs;
          want.checksum_ok    = (cs == 16'h0000);
          want.too_long       = ovr;
          csum_q.push_back(want);
          in_seg    = 1'b0;
          pair_sum  = '0;
          byte_cnt  = '0;
          high_byte = '0;
          odd_half  = 1'b0;
        end
      end

      fails_o   <= n_fail;
      pending_o <= csum_q.size();
      results_o <= n_res;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
module tb;

  localparam int unsigned CycleLimit  = 40000;
  localparam int unsigned LongStall   = 300;
  localparam int unsigned RandomBytes = 1400;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  ucs_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ucs_pkg::out_item_t out_data;

  logic        calm      = 1'b0;
  logic        stall_req = 1'b0;
  logic        stall_ack = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycles     = 0;

  int unsigned fails;
  int unsigned pending;
  int unsigned results;

  logic [7:0]  seg_buf[$];
  int unsigned n_bytes = 0;
  int unsigned n_segs  = 0;
  int unsigned seg_no;
  int unsigned kind;
  int unsigned k;
  int unsigned goal;
  logic [31:0] src;
  logic [31:0] dst;

  udp_checksum_engine_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  udp_csum_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fails_o     (fails),
    .pending_o   (pending),
    .results_o   (results)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL udp_checksum_engine_unit");
      $finish;
    end
  end

  // The receiver counts a long hold-off itself once the sender asks for one.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req != stall_ack) begin
      out_ready  <= 1'b0;
      stall_left <= LongStall;
      stall_ack  <= stall_req;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  task automatic random_bytes(input int unsigned len);
    seg_buf.delete();
    repeat (len) seg_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Writes the pair at pos so that the whole one's-complement sum folds to all ones.
  task automatic seal_at(input int unsigned pos, input logic fill,
                         input logic [31:0] sa, input logic [31:0] da);
    int unsigned acc;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [15:0] ck;
    acc = sa[31:16] + sa[15:0] + da[31:16] + da[15:0] + ucs_pkg::UdpProtocol +
          seg_buf.size();
    for (int i = 0; i < seg_buf.size(); i += 2) begin
      hi = seg_buf[i];
      lo = (i + 1 < seg_buf.size()) ? seg_buf[i+1] : 8'h00;
      if (i == pos || (fill && i == 6)) begin
        hi = 8'h00;
        lo = 8'h00;
      end
      acc += {hi, lo};
    end
    while (acc > 32'hFFFF) acc = (acc & 32'hFFFF) + (acc >> 16);
    ck = ~acc[15:0];
    seg_buf[pos]   = ck[15:8];
    seg_buf[pos+1] = ck[7:0];
  endtask

  task automatic send_segment(input logic fill, input logic [31:0] sa,
                              input logic [31:0] da);
    ucs_pkg::in_item_t it;
    int unsigned       n;
    n = seg_buf.size();
    for (int i = 0; i < n; i++) begin
      it.func      = (i == 0 || $urandom_range(0, 9) != 0) ? fill
                                                            : 1'($urandom_range(0, 1));
      it.data_byte = seg_buf[i];
      it.last_byte = (i == n - 1);
      it.src_ip    = (i == 0) ? sa : $urandom;
      it.dst_ip    = (i == 0) ? da : $urandom;
      in_valid <= 1'b1;
      in_data  <= it;
      do @(posedge clk); while (!in_ready);
      n_bytes++;
      if (!calm && $urandom_range(0, 99) < 8) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
    n_segs++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    seg_buf = {8'h00};
    send_segment(1'b0, 32'h0000_0000, 32'h0000_0000);
    seg_buf = {8'hFF};
    send_segment(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    src = $urandom;
    dst = $urandom;
    random_bytes(9);
    seal_at(6, 1'b0, src, dst);
    send_segment(1'b0, src, dst);
    src = $urandom;
    dst = $urandom;
    random_bytes(10);
    seg_buf[6] = 8'hFF;
    seg_buf[7] = 8'hFF;
    seal_at(8, 1'b1, src, dst);
    send_segment(1'b1, src, dst);
    drain();

    goal = n_bytes + RandomBytes;
    seg_no = 0;
    while (n_bytes < goal) begin
      seg_no++;
      if (seg_no == 25) begin
        stall_req <= ~stall_req;
        repeat (16) begin
          random_bytes(1);
          send_segment(1'($urandom_range(0, 1)), $urandom, $urandom);
        end
        drain();
      end
      if (seg_no == 40) calm <= 1'b1;
      if (seg_no == 70) calm <= 1'b0;
      if (seg_no % 30 == 0) drain();
      kind = $urandom_range(0, 99);
      src  = $urandom;
      dst  = $urandom;
      if (kind < 45) begin
        random_bytes($urandom_range(8, 48));
        seal_at(6, 1'b0, src, dst);
        if ($urandom_range(0, 7) == 0) begin
          k = $urandom_range(0, seg_buf.size() - 1);
          seg_buf[k] = seg_buf[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        send_segment(1'b0, src, dst);
      end else if (kind < 65) begin
        random_bytes($urandom_range(10, 48));
        if ($urandom_range(0, 3) == 0) seal_at(8, 1'b1, src, dst);
        send_segment(1'b1, src, dst);
      end else if (kind < 85) begin
        random_bytes($urandom_range(1, 7));
        send_segment(1'($urandom_range(0, 1)), src, dst);
      end else begin
        random_bytes($urandom_range(49, 300));
        send_segment(1'($urandom_range(0, 1)), src, dst);
      end
    end

    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d segments in %0d byte transfers: one-byte, odd, sealed,",
             n_segs, n_bytes);
    $display("fill-mode and mode-switching segments under stalls; %0d checksums compared.",
             results);
    if (fails == 0) begin
      $display("PASS udp_checksum_engine_unit");
    end else begin
      $display("FAIL udp_checksum_engine_unit");
    end
    $finish;
  end

endmodule
